// ----- rtl/fwmi_pkg.sv -----
// Shared types and constants for the queue with insert by value.
// No dependencies; imported by every module of the block.
package fwmi_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // command codes
   localparam logic [1:0] OP_ENQUEUE    = 2'd0;
   localparam logic [1:0] OP_DEQUEUE    = 2'd1;
   localparam logic [1:0] OP_INS_AFTER  = 2'd2;
   localparam logic [1:0] OP_INS_BEFORE = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [CNT_W-1:0]      count_type;

   // command as seen by every cell
   typedef struct packed {
      logic [1:0] opcode;
      word_type   match_word;
      word_type   new_word;
      logic       commit;
   } cell_cmd_type;

   // passed from a cell to the cell behind it (toward the tail)
   typedef struct packed {
      logic     valid;
      word_type word;
      logic     hit_below;   // a match in some cell ahead of the sender
      logic     hit_upto;    // a match in the sender or ahead of it
   } fwd_link_type;

   // passed from a cell to the cell ahead of it (toward the head)
   typedef struct packed {
      logic     valid;
      word_type word;
   } bwd_link_type;

endpackage

// ----- rtl/fwmi_cell.sv -----
// One queue entry: word, valid flag, match compare and shift decision.
// Depends on fwmi_pkg.
module fwmi_cell
   import fwmi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  fwd_link_type from_left,
   input  bwd_link_type from_right,
   output fwd_link_type to_right,
   output bwd_link_type to_left
);

   logic     valid_ff, valid_in;
   word_type word_ff, word_in;
   logic     match;
   logic     left_first;

   assign match      = valid_ff && (word_ff == cmd.match_word);
   assign left_first = from_left.hit_upto && !from_left.hit_below;

   assign to_right.valid     = valid_ff;
   assign to_right.word      = word_ff;
   assign to_right.hit_below = from_left.hit_upto;
   assign to_right.hit_upto  = from_left.hit_upto || match;

   assign to_left.valid = valid_ff;
   assign to_left.word  = word_ff;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (cmd.commit) begin
         unique case (cmd.opcode)
            OP_ENQUEUE: begin
               // take the word at the first free place
               if (from_left.valid && !valid_ff) begin
                  valid_in = 1'b1;
                  word_in  = cmd.new_word;
               end
            end
            OP_DEQUEUE: begin
               valid_in = from_right.valid;
               word_in  = from_right.word;
            end
            OP_INS_AFTER: begin
               valid_in = from_left.valid;
               if (from_left.hit_below) begin
                  word_in = from_left.word;
               end else if (left_first) begin
                  word_in = cmd.new_word;
               end
            end
            OP_INS_BEFORE: begin
               valid_in = from_left.valid;
               if (from_left.hit_upto) begin
                  word_in = from_left.word;
               end else if (match) begin
                  word_in = cmd.new_word;
               end
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

endmodule

// ----- rtl/fifo_with_match_insert.sv -----
// Top level of the queue with insert by value: command register, row of cells,
// status decision and result register. Depends on fwmi_pkg and fwmi_cell.
//
// An ordered queue of CAPACITY words held in a row of cells, head in the first
// cell. A command is registered on acceptance and carried out from the command
// register once the result register can take it: every cell compares its word with
// the match value at once and shifts, loads or holds, and the result beat is
// registered in the result register. A new command is taken in the same cycle as
// the previous one executes, so the block sustains one command per cycle unless the
// receiver stalls; it stalls only while the result register is full and held by the
// receiver. Reset empties the queue.
module fifo_with_match_insert
   import fwmi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_match_value,
   input  logic [31:0] req_new_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_head_word,
   output logic [4:0]  rsp_entry_count,
   output logic        rsp_queue_empty
);

   logic       cmd_valid_ff, cmd_valid_in;
   logic [1:0] op_ff;
   word_type   match_ff;
   word_type   new_ff;
   count_type  count_ff, count_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_head_ff, rsp_head_in;
   logic [4:0]  rsp_count_ff;
   logic        rsp_empty_ff;

   logic         accept;
   logic         exec;
   logic         full;
   logic         found;
   cell_cmd_type cmd;

   fwd_link_type fwd [CAPACITY+1];
   bwd_link_type bwd [CAPACITY+1];

   assign exec      = cmd_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = cmd_valid_ff && !exec;
   assign accept    = req_valid && !req_stall;
   assign cmd_valid_in = accept || (cmd_valid_ff && !exec);

   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign found = fwd[CAPACITY].hit_upto;

   // status of the command now executing
   always_comb begin
      priority if (op_ff == OP_DEQUEUE) begin
         rsp_status_in = (count_ff == '0) ? ST_EMPTY : ST_OK;
      end else if (full) begin
         rsp_status_in = ST_FULL;
      end else if (op_ff == OP_ENQUEUE) begin
         rsp_status_in = ST_OK;
      end else if (!found) begin
         rsp_status_in = ST_NOT_FOUND;
      end else begin
         rsp_status_in = ST_OK;
      end
   end

   assign cmd.opcode     = op_ff;
   assign cmd.match_word = match_ff;
   assign cmd.new_word   = new_ff;
   assign cmd.commit     = exec && (rsp_status_in == ST_OK);

   always_comb begin
      count_in = count_ff;
      if (cmd.commit) begin
         if (op_ff == OP_DEQUEUE) begin
            count_in = count_ff - CNT_W'(1);
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   assign rsp_head_in = (cmd.commit && op_ff == OP_DEQUEUE)
                      ? 32'({32'd0, fwd[1].word}) : 32'd0;

   // boundaries of the row: ahead of the head everything counts as held
   assign fwd[0].valid     = 1'b1;
   assign fwd[0].word      = '0;
   assign fwd[0].hit_below = 1'b0;
   assign fwd[0].hit_upto  = 1'b0;
   assign bwd[CAPACITY].valid = 1'b0;
   assign bwd[CAPACITY].word  = '0;
   assign bwd[0].valid = 1'b0;
   assign bwd[0].word  = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      bwd_link_type left_out;
      fwmi_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .from_left  (fwd[i]),
         .from_right (bwd[i+1]),
         .to_right   (fwd[i+1]),
         .to_left    (left_out)
      );
      if (i > 0) begin : g_link
         assign bwd[i] = left_out;
      end
   end

   assign rsp_valid_in = exec || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         op_ff    <= req_opcode;
         match_ff <= DATA_WIDTH'({{DATA_WIDTH{1'b0}}, req_match_value});
         new_ff   <= DATA_WIDTH'({{DATA_WIDTH{1'b0}}, req_new_value});
      end
      if (exec) begin
         rsp_status_ff <= rsp_status_in;
         rsp_head_ff   <= rsp_head_in;
         rsp_count_ff  <= 5'({5'd0, count_in});
         rsp_empty_ff  <= (count_in == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_head_word   = rsp_head_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_queue_empty = rsp_empty_ff;

endmodule

// ----- rtl/fwmi_check.sv -----
// Port-level checks for the queue with insert by value, bound to the top level.
// Depends on fwmi_pkg and fifo_with_match_insert.
module fwmi_check
   import fwmi_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_opcode,
   input logic [31:0] req_match_value,
   input logic [31:0] req_new_value,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_head_word,
   input logic [4:0]  rsp_entry_count,
   input logic        rsp_queue_empty
);

   // empty flag agrees with the count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_queue_empty == (rsp_entry_count == 5'd0)))
      else $error("queue_empty disagrees with entry_count");

   // only a successful dequeue returns a word
   a_head_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_head_word != 32'd0) |-> (rsp_status == ST_OK))
      else $error("head word returned with failing status");

   // a full refusal leaves the queue at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_entry_count == 5'(CAPACITY)))
      else $error("full status with count below capacity");

   // an empty refusal means nothing is held
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> rsp_queue_empty)
      else $error("empty status with entries held");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
                                    && $stable(rsp_head_word)
                                    && $stable(rsp_entry_count)))
      else $error("result beat changed while stalled");

endmodule

bind fifo_with_match_insert fwmi_check u_fwmi_check (.*);

// ----- verif/tb.sv -----
// Self-checking bench for the queue with insert by value: queued driver, clocked
// monitor and a predictor that keeps its own copy of the entries.
// Depends on fwmi_pkg and fifo_with_match_insert.
module tb;
   import fwmi_pkg::*;

   typedef struct {
      logic [1:0] opcode;
      word_type   match_word;
      word_type   new_word;
      int         phase;
   } cmd_item_type;

   typedef struct packed {
      logic [1:0] status;
      word_type   head_word;
      count_type  entry_count;
      logic       queue_empty;
   } queue_result_type;

   localparam int IDLE_LIMIT = 4000;
   localparam int RAND_PER_PHASE = 375;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = OP_ENQUEUE;
   logic [31:0] req_match_value = '0;
   logic [31:0] req_new_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_head_word;
   logic [4:0]  rsp_entry_count;
   logic        rsp_queue_empty;

   cmd_item_type     command_queue[$];
   queue_result_type pending_results[$];
   word_type         model_words[CAPACITY];
   int               model_fill = 0;
   int               run_phase = 0;
   int               mismatch_count = 0;
   int               idle_cycles = 0;
   word_type         value_pool[8];

   fifo_with_match_insert i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_match_value (req_match_value),
      .req_new_value   (req_new_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_head_word   (rsp_head_word),
      .rsp_entry_count (rsp_entry_count),
      .rsp_queue_empty (rsp_queue_empty)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int send_idle_pct(int phase);
      case (phase)
         1:       return 84;
         3:       return 38;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct(int phase);
      case (phase)
         2:       return 84;
         3:       return 38;
         default: return 0;
      endcase
   endfunction

   // Carry out one command on the local copy of the queue and return its result.
   function automatic queue_result_type apply_command(logic [1:0] opcode,
                                                      word_type match_word,
                                                      word_type new_word);
      queue_result_type res;
      int pos;
      int i;
      res.status    = ST_OK;
      res.head_word = '0;
      if (opcode == OP_DEQUEUE) begin
         if (model_fill == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.head_word = model_words[0];
            for (i = 1; i < model_fill; i++) model_words[i-1] = model_words[i];
            model_fill--;
         end
      end else if (model_fill >= CAPACITY) begin
         res.status = ST_FULL;
      end else begin
         if (opcode == OP_ENQUEUE) begin
            pos = model_fill;
         end else begin
            // first match nearest the head wins
            pos = model_fill;
            for (i = model_fill - 1; i >= 0; i--) begin
               if (model_words[i] == match_word) pos = i;
            end
            if (pos < model_fill && opcode == OP_INS_AFTER) pos++;
            else if (pos >= model_fill) pos = -1;
         end
         if (pos < 0) begin
            res.status = ST_NOT_FOUND;
         end else begin
            for (i = model_fill; i > pos; i--) model_words[i] = model_words[i-1];
            model_words[pos] = new_word;
            model_fill++;
         end
      end
      res.entry_count = count_type'(model_fill);
      res.queue_empty = (model_fill == 0);
      return res;
   endfunction

   task automatic add_cmd(logic [1:0] opcode, word_type match_word, word_type new_word,
                          int phase);
      cmd_item_type item;
      item.opcode     = opcode;
      item.match_word = match_word;
      item.new_word   = new_word;
      item.phase      = phase;
      command_queue.push_back(item);
   endtask

   // Mostly words from a small pool so that searches hit, now and then any word.
   function automatic word_type pick_word();
      if ($urandom_range(3) != 0) return value_pool[$urandom_range(7)];
      return $urandom;
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_val,
                                       logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
         mismatch_count++;
      end
   endfunction

   // driver: advance to the next pending command once the current beat is taken
   always @(posedge clock) begin : drive_proc
      cmd_item_type next_cmd;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            pending_results.push_back(apply_command(req_opcode, req_match_value, req_new_value));
         end
         if (command_queue.size() > 0 &&
             $urandom_range(99) >= send_idle_pct(command_queue[0].phase)) begin
            next_cmd = command_queue.pop_front();
            req_opcode      <= next_cmd.opcode;
            req_match_value <= next_cmd.match_word;
            req_new_value   <= next_cmd.new_word;
            req_valid       <= 1'b1;
            run_phase       <= next_cmd.phase;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: compare each result beat with the oldest prediction
   always @(posedge clock) begin : monitor_proc
      queue_result_type exp_res;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result beat with nothing expected, status %h count %h",
                        $time, rsp_status, rsp_entry_count);
               mismatch_count++;
            end else begin
               exp_res = pending_results.pop_front();
               check_field("status", 32'(exp_res.status), 32'(rsp_status));
               check_field("head_word", 32'(exp_res.head_word), rsp_head_word);
               check_field("entry_count", 32'(exp_res.entry_count), 32'(rsp_entry_count));
               check_field("queue_empty", 32'(exp_res.queue_empty), 32'(rsp_queue_empty));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct(run_phase));
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : stimulus_proc
      int phase;
      int n;
      int drain_bias;
      logic [1:0] opcode;
      value_pool[0] = '0;
      value_pool[1] = '1;
      for (n = 2; n < 8; n++) value_pool[n] = $urandom;

      // empty queue: dequeue and both inserts must fail
      add_cmd(OP_DEQUEUE, '0, '0, 0);
      add_cmd(OP_INS_AFTER, '0, 32'h1111_1111, 0);
      add_cmd(OP_INS_BEFORE, '1, 32'h2222_2222, 0);
      // duplicates, inserts at head, middle and behind a given entry
      add_cmd(OP_ENQUEUE, '0, '0, 0);
      add_cmd(OP_ENQUEUE, '0, '1, 0);
      add_cmd(OP_ENQUEUE, '1, '0, 0);
      add_cmd(OP_INS_AFTER, '0, 32'hA5A5_A5A5, 0);
      add_cmd(OP_INS_BEFORE, '0, 32'h5A5A_5A5A, 0);
      add_cmd(OP_INS_AFTER, '1, 32'h0000_0001, 0);
      add_cmd(OP_INS_BEFORE, 32'h1234_5678, '1, 0);
      add_cmd(OP_DEQUEUE, '1, '1, 0);
      // fill up, then hit the full cases with and without a match
      for (n = 0; n < 11; n++) add_cmd(OP_ENQUEUE, $urandom, $urandom, 0);
      add_cmd(OP_ENQUEUE, '0, '1, 0);
      add_cmd(OP_INS_AFTER, '0, '1, 0);
      add_cmd(OP_INS_BEFORE, 32'h1234_5678, '0, 0);

      // random part: stretches that are fill-heavy or drain-heavy, chosen at random
      for (phase = 0; phase < 4; phase++) begin
         for (n = 0; n < RAND_PER_PHASE; n++) begin
            if (n % 24 == 0) drain_bias = $urandom_range(1) ? 70 : 20;
            if ($urandom_range(99) < drain_bias) begin
               opcode = OP_DEQUEUE;
            end else begin
               case ($urandom_range(3))
                  0:       opcode = OP_ENQUEUE;
                  1:       opcode = OP_INS_AFTER;
                  2:       opcode = OP_INS_BEFORE;
                  default: opcode = 2'($urandom_range(3));
               endcase
            end
            add_cmd(opcode, pick_word(), pick_word(), phase);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // sample between edges so the driver's updates have settled
      while (command_queue.size() > 0 || req_valid || pending_results.size() > 0) begin
         @(negedge clock);
      end
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
